>>> rtl/pfx_pkg.sv
// shared types and constants for the postfix expression evaluator
package pfx_pkg;

    localparam int DEPTH_DEFAULT = 256;
    localparam int DATA_W        = 32;
    localparam int SYM_W         = 8;
    localparam int ERR_W         = 2;
    localparam int DIV_STEPS     = DATA_W;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

    // ascii codes
    localparam logic [SYM_W-1:0] SYM_ZERO   = 8'h30;
    localparam logic [SYM_W-1:0] SYM_NINE   = 8'h39;
    localparam logic [SYM_W-1:0] SYM_PLUS   = 8'h2b;
    localparam logic [SYM_W-1:0] SYM_MINUS  = 8'h2d;
    localparam logic [SYM_W-1:0] SYM_TIMES  = 8'h2a;
    localparam logic [SYM_W-1:0] SYM_DIVIDE = 8'h2f;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_UNDER = 2'd1;
    localparam logic [ERR_W-1:0] ERR_OVER  = 2'd2;
    localparam logic [ERR_W-1:0] ERR_DIV0  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POP_A,
        ST_POP_B,
        ST_LOAD_B,
        ST_CALC,
        ST_DIV,
        ST_PUSH,
        ST_FIN,
        ST_FETCH_TOP,
        ST_EMIT
    } pfx_state_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
    } pfx_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [ERR_W-1:0]         error;
    } pfx_out_t;

endpackage

>>> rtl/pfx_ram.sv
// generic single-port-write, single-port-read ram with registered read
module pfx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/postfix_expression_evaluator.sv
// postfix expression evaluator: ram operand stack with a sequencer and iterative divider
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------
//  sym      | sym_valid / sym_stall      | sym_item: symbol, last
//  result   | result_valid / result_stall| result: value, error
//
// one item at a time: a digit is pushed; +, - and * read two operands from the stack
// through the registered ram read port, compute and push the result; unknown
// symbols read the two and push nothing; / runs the one-bit-per-cycle divider before
// its push. an item with last then reads the top of the stack and loads the output,
// skipping the read on an empty stack.
// reset clears depth, error and the output valid; stack contents are not cleared.
// a stalled result holds in the output register; the block keeps taking items
// and only waits if another result is ready before the previous one is taken.
module postfix_expression_evaluator
    import pfx_pkg::*;
#(
    parameter int STACK_DEPTH = DEPTH_DEFAULT
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     sym_valid,
    output logic     sym_stall,
    input  pfx_in_t  sym_item,
    output logic     result_valid,
    input  logic     result_stall,
    output pfx_out_t result
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam logic [DW-1:0] FULL = DW'(STACK_DEPTH);

    pfx_state_t state_reg, state_next;

    logic [DW-1:0]        depth_reg, depth_next;
    logic [ERR_W-1:0]     err_reg, err_next;
    logic [SYM_W-1:0]     sym_reg, sym_next;
    logic                 last_reg, last_next;
    logic [DATA_W-1:0]    a_reg, a_next;
    logic [DATA_W-1:0]    b_reg, b_next;
    logic [DATA_W-1:0]    push_val_reg, push_val_next;
    logic                 rd_hit_reg, rd_hit_next;
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    dq_reg, dq_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 neg_reg, neg_next;
    logic [DATA_W-1:0]    val_reg, val_next;
    logic                 out_valid_reg, out_valid_next;
    pfx_out_t             out_data_reg, out_data_next;

    // stack memory ports
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    // divider datapath
    logic [DATA_W:0]   div_shift;
    logic [DATA_W:0]   div_diff;
    logic              div_ge;
    logic [DATA_W-1:0] div_quot;

    logic [DATA_W-1:0] rd_operand;
    logic              out_free;
    logic              in_accept;
    logic [DW-1:0]     depth_dec;

    pfx_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // first error of an expression is kept
    function automatic logic [ERR_W-1:0] flag_err(input logic [ERR_W-1:0] cur,
                                                  input logic [ERR_W-1:0] code);
        return (cur == ERR_NONE) ? code : cur;
    endfunction

    assign sym_stall    = (state_reg != ST_IDLE);
    assign in_accept    = sym_valid && !sym_stall;
    assign out_free     = !out_valid_reg || !result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // a pop of an empty stack reads as zero
    assign rd_operand = rd_hit_reg ? ram_rdata : '0;
    assign depth_dec  = depth_reg - DW'(1);

    // one restoring step of the divider
    assign div_shift = {rem_reg, dq_reg[DATA_W-1]};
    assign div_diff  = div_shift - {1'b0, a_reg};
    assign div_ge    = (div_shift >= {1'b0, a_reg});
    assign div_quot  = {dq_reg[DATA_W-2:0], div_ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            depth_reg     <= '0;
            err_reg       <= ERR_NONE;
            rd_hit_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            err_reg       <= err_next;
            rd_hit_reg    <= rd_hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg      <= sym_next;
        last_reg     <= last_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        push_val_reg <= push_val_next;
        rem_reg      <= rem_next;
        dq_reg       <= dq_next;
        div_cnt_reg  <= div_cnt_next;
        neg_reg      <= neg_next;
        val_reg      <= val_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        depth_next     = depth_reg;
        err_next       = err_reg;
        sym_next       = sym_reg;
        last_next      = last_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        push_val_next  = push_val_reg;
        rd_hit_next    = 1'b0;
        rem_next       = rem_reg;
        dq_next        = dq_reg;
        div_cnt_next   = div_cnt_reg;
        neg_next       = neg_reg;
        val_next       = val_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_data_next  = out_data_reg;

        ram_we    = 1'b0;
        ram_waddr = depth_reg[AW-1:0];
        ram_wdata = push_val_reg;
        ram_re    = 1'b0;
        ram_raddr = depth_dec[AW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    sym_next  = sym_item.symbol;
                    last_next = sym_item.last;
                    if (sym_item.symbol >= SYM_ZERO && sym_item.symbol <= SYM_NINE)
                    begin
                        push_val_next = DATA_W'(sym_item.symbol - SYM_ZERO);
                        state_next    = ST_PUSH;
                    end
                    else
                    begin
                        state_next = ST_POP_A;
                    end
                end
            end

            // pop a: issue the read of the top
            ST_POP_A:
            begin
                if (depth_reg == '0)
                begin
                    err_next = flag_err(err_reg, ERR_UNDER);
                end
                else
                begin
                    ram_re      = 1'b1;
                    rd_hit_next = 1'b1;
                    depth_next  = depth_dec;
                end
                state_next = ST_POP_B;
            end

            // capture a, issue the read of b
            ST_POP_B:
            begin
                a_next = rd_operand;
                if (depth_reg == '0)
                begin
                    err_next = flag_err(err_reg, ERR_UNDER);
                end
                else
                begin
                    ram_re      = 1'b1;
                    rd_hit_next = 1'b1;
                    depth_next  = depth_dec;
                end
                state_next = ST_LOAD_B;
            end

            ST_LOAD_B:
            begin
                b_next     = rd_operand;
                state_next = ST_CALC;
            end

            ST_CALC:
            begin
                case (sym_reg)
                    SYM_PLUS:
                    begin
                        push_val_next = b_reg + a_reg;
                        state_next    = ST_PUSH;
                    end
                    SYM_MINUS:
                    begin
                        push_val_next = b_reg - a_reg;
                        state_next    = ST_PUSH;
                    end
                    SYM_TIMES:
                    begin
                        push_val_next = b_reg * a_reg;
                        state_next    = ST_PUSH;
                    end
                    SYM_DIVIDE:
                    begin
                        if (a_reg == '0)
                        begin
                            err_next      = flag_err(err_reg, ERR_DIV0);
                            push_val_next = '0;
                            state_next    = ST_PUSH;
                        end
                        else
                        begin
                            // divide magnitudes, fix the sign at the end
                            neg_next     = a_reg[DATA_W-1] ^ b_reg[DATA_W-1];
                            a_next       = a_reg[DATA_W-1] ? (~a_reg + DATA_W'(1)) : a_reg;
                            dq_next      = b_reg[DATA_W-1] ? (~b_reg + DATA_W'(1)) : b_reg;
                            rem_next     = '0;
                            div_cnt_next = '0;
                            state_next   = ST_DIV;
                        end
                    end
                    default:
                    begin
                        // unknown operator: operands are dropped
                        state_next = ST_FIN;
                    end
                endcase
            end

            ST_DIV:
            begin
                rem_next     = div_ge ? div_diff[DATA_W-1:0] : div_shift[DATA_W-1:0];
                dq_next      = div_quot;
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    push_val_next = neg_reg ? (~div_quot + DATA_W'(1)) : div_quot;
                    state_next    = ST_PUSH;
                end
            end

            ST_PUSH:
            begin
                if (depth_reg < FULL)
                begin
                    ram_we     = 1'b1;
                    depth_next = depth_reg + DW'(1);
                end
                else
                begin
                    err_next = flag_err(err_reg, ERR_OVER);
                end
                state_next = ST_FIN;
            end

            // end of item: on last, pop the top for the result
            ST_FIN:
            begin
                if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (depth_reg == '0)
                begin
                    err_next   = flag_err(err_reg, ERR_UNDER);
                    val_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = ST_FETCH_TOP;
                end
            end

            ST_FETCH_TOP:
            begin
                val_next   = ram_rdata;
                state_next = ST_EMIT;
            end

            // load the output register once it is free, then clear the stack
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_data_next.value = val_reg;
                    out_data_next.error = err_reg;
                    depth_next          = '0;
                    err_next            = ERR_NONE;
                    state_next          = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> sim/tb.sv
// self-checking testbench for the postfix expression evaluator
module tb;
    import pfx_pkg::*;

    // stack size of the instance, also used by the expression predictor
    localparam int STACK_SIZE = DEPTH_DEFAULT;

    // characters with no meaning to the evaluator
    localparam logic [SYM_W-1:0] SYM_QUERY    = 8'h3f;
    localparam logic [SYM_W-1:0] SYM_NUL      = 8'h00;
    localparam logic [SYM_W-1:0] SYM_ALL_ONES = 8'hff;

    // long receiver hold-off used to fill the block up
    localparam int HOLD_CYCLES    = 400;
    // cycles without any item moving on either channel before giving up
    localparam int WATCHDOG_LIMIT = 4000;
    // quiet cycles after the last expected result, covers a full divide
    localparam int DRAIN_CYCLES   = 100;
    localparam int RANDOM_ITEMS   = 840;

    logic     clk;
    logic     rst_n;
    logic     sym_valid;
    logic     sym_stall;
    pfx_in_t  sym_item;
    logic     result_valid;
    logic     result_stall;
    pfx_out_t result;

    postfix_expression_evaluator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sym_valid    (sym_valid),
        .sym_stall    (sym_stall),
        .sym_item     (sym_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // expression predictor: operand stack, fill level and sticky error
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] operand_mem [STACK_SIZE];
    int                stack_fill = 0;
    logic [ERR_W-1:0]  sticky_err = ERR_NONE;

    // results the block still owes, oldest first
    pfx_out_t expected_results [$];

    int  mismatch_count = 0;
    int  symbols_sent   = 0;
    // random idling on both sides, switched off for the last stretch
    bit  idle_on        = 1'b1;
    // asks the receiver for one long hold-off
    bit  hold_request   = 1'b0;

    // only the first error of an expression is kept
    function automatic void raise_error(input logic [ERR_W-1:0] code);
        if (sticky_err == ERR_NONE)
            sticky_err = code;
    endfunction

    // a push onto a full stack is lost
    function automatic void push_operand(input logic [DATA_W-1:0] v);
        if (stack_fill >= STACK_SIZE) begin
            raise_error(ERR_OVER);
            return;
        end
        operand_mem[stack_fill] = v;
        stack_fill++;
    endfunction

    // an empty stack reads as zero
    function automatic logic [DATA_W-1:0] pop_operand();
        if (stack_fill == 0) begin
            raise_error(ERR_UNDER);
            return '0;
        end
        stack_fill--;
        return operand_mem[stack_fill];
    endfunction

    // applies one character; returns 1 with the result when it closes an expression
    function automatic bit evaluate_symbol(input pfx_in_t it, output pfx_out_t res);
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        longint            quot;
        res = '0;
        if (it.symbol >= SYM_ZERO && it.symbol <= SYM_NINE) begin
            push_operand({24'd0, it.symbol - SYM_ZERO});
        end else begin
            a = pop_operand();
            b = pop_operand();
            case (it.symbol)
                SYM_PLUS:   push_operand(b + a);
                SYM_MINUS:  push_operand(b - a);
                SYM_TIMES:  push_operand(b * a);
                SYM_DIVIDE: begin
                    if (a == '0) begin
                        raise_error(ERR_DIV0);
                        push_operand('0);
                    end else begin
                        // 64-bit quotient so that the most negative over minus one wraps
                        quot = longint'($signed(b)) / longint'($signed(a));
                        push_operand(quot[DATA_W-1:0]);
                    end
                end
                default: ;
            endcase
        end
        if (!it.last)
            return 1'b0;
        res.value  = pop_operand();
        res.error  = sticky_err;
        stack_fill = 0;
        sticky_err = ERR_NONE;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // mismatch reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // symbol sender: drives at the falling edge, item taken at a rising
    // edge with valid high and stall low, prediction made right there
    // ------------------------------------------------------------------
    task automatic send_symbol(input logic [SYM_W-1:0] sym, input bit is_last);
        pfx_in_t  it;
        pfx_out_t res;
        it.symbol = sym;
        it.last   = is_last;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            sym_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        sym_valid = 1'b1;
        sym_item  = it;
        do @(posedge clk); while (sym_stall !== 1'b0);
        if (evaluate_symbol(it, res))
            expected_results.push_back(res);
        symbols_sent++;
        @(negedge clk);
    endtask

    function automatic logic [SYM_W-1:0] digit(input int d);
        return SYM_ZERO + SYM_W'(d);
    endfunction

    function automatic logic [SYM_W-1:0] random_operator();
        case ($urandom_range(0, 3))
            0:       return SYM_PLUS;
            1:       return SYM_MINUS;
            2:       return SYM_TIMES;
            default: return SYM_DIVIDE;
        endcase
    endfunction

    // well-formed postfix with random digits and operators; with allow_corrupt, a few
    // operators are swapped for arbitrary characters to break the sequence
    task automatic send_wellformed(input int n_digits, input bit digits_first,
                                   input bit allow_corrupt);
        logic [SYM_W-1:0] seq [$];
        int               pending;
        int               digits_left;
        pending     = 0;
        digits_left = n_digits;
        while (digits_left > 0 || pending > 1) begin
            if (pending >= 2 && (digits_left == 0 ||
                (!digits_first && $urandom_range(0, 2) == 0))) begin
                if (allow_corrupt && $urandom_range(0, 29) == 0)
                    seq.push_back(SYM_W'($urandom_range(0, 255)));
                else
                    seq.push_back(random_operator());
                pending--;
            end else begin
                seq.push_back(digit($urandom_range(0, 9)));
                pending++;
                digits_left--;
            end
        end
        foreach (seq[i])
            send_symbol(seq[i], i == seq.size() - 1);
    endtask

    // arbitrary bytes, closed by a last flag on the final one
    task automatic send_noise();
        int len;
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
            send_symbol(SYM_W'($urandom_range(0, 255)), i == len - 1);
    endtask

    // ------------------------------------------------------------------
    // receiver: random stall bursts, one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        result_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                result_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                result_stall = 1'b1;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            result_stall = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // result checker: every taken result against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        pfx_out_t want;
        if (rst_n && result_valid === 1'b1 && result_stall === 1'b0) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result value %0d error %0d",
                                          result.value, result.error));
            end else begin
                want = expected_results.pop_front();
                if (result.value !== want.value)
                    report_mismatch($sformatf("value %0d, expected %0d",
                                              result.value, want.value));
                if (result.error !== want.error)
                    report_mismatch($sformatf("error %0d, expected %0d",
                                              result.error, want.error));
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long with nothing moving on either channel
    // ------------------------------------------------------------------
    int quiet_cycles = 0;
    always @(posedge clk) begin
        if ((sym_valid && !sym_stall) || (result_valid && !result_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("postfix_expression_evaluator verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // each operator, digit extremes, truncation and odd characters
    task automatic test_arithmetic();
        send_symbol(digit(0), 1'b1);
        send_symbol(digit(9), 1'b1);
        send_symbol(digit(9), 1'b0);
        send_symbol(digit(9), 1'b0);
        send_symbol(SYM_TIMES, 1'b1);
        send_symbol(digit(0), 1'b0);
        send_symbol(digit(9), 1'b0);
        send_symbol(SYM_MINUS, 1'b1);
        // -7 / 2 truncates toward zero
        send_symbol(digit(0), 1'b0);
        send_symbol(digit(7), 1'b0);
        send_symbol(SYM_MINUS, 1'b0);
        send_symbol(digit(2), 1'b0);
        send_symbol(SYM_DIVIDE, 1'b1);
        send_symbol(digit(8), 1'b0);
        send_symbol(digit(9), 1'b0);
        send_symbol(SYM_PLUS, 1'b1);
        // unknown characters pop two and push nothing
        send_symbol(digit(3), 1'b0);
        send_symbol(digit(8), 1'b0);
        send_symbol(SYM_NUL, 1'b0);
        send_symbol(digit(6), 1'b1);
        send_symbol(SYM_ALL_ONES, 1'b1);
    endtask

    // pops from an empty stack read zero and flag underflow
    task automatic test_underflow();
        send_symbol(SYM_PLUS, 1'b1);
        send_symbol(digit(7), 1'b0);
        send_symbol(SYM_MINUS, 1'b1);
        // last on an emptied stack with no earlier error
        send_symbol(digit(3), 1'b0);
        send_symbol(digit(4), 1'b0);
        send_symbol(SYM_QUERY, 1'b1);
    endtask

    // divide by zero pushes zero; the first error wins over later ones
    task automatic test_divide_by_zero();
        send_symbol(digit(5), 1'b0);
        send_symbol(digit(0), 1'b0);
        send_symbol(SYM_DIVIDE, 1'b1);
        send_symbol(digit(5), 1'b0);
        send_symbol(digit(0), 1'b0);
        send_symbol(SYM_DIVIDE, 1'b0);
        send_symbol(SYM_PLUS, 1'b1);
        send_symbol(digit(5), 1'b0);
        send_symbol(digit(0), 1'b0);
        send_symbol(SYM_DIVIDE, 1'b0);
        send_symbol(digit(3), 1'b1);
    endtask

    // 2 * 8^10 wraps to the most negative value, then divided by minus one
    task automatic test_most_negative_divide();
        send_symbol(digit(2), 1'b0);
        repeat (10) begin
            send_symbol(digit(8), 1'b0);
            send_symbol(SYM_TIMES, 1'b0);
        end
        send_symbol(digit(0), 1'b0);
        send_symbol(digit(1), 1'b0);
        send_symbol(SYM_MINUS, 1'b0);
        send_symbol(SYM_DIVIDE, 1'b1);
    endtask

    // fill the stack, one push too many, then reduce and close
    task automatic test_overflow();
        repeat (STACK_SIZE) send_symbol(digit(1), 1'b0);
        send_symbol(digit(5), 1'b0);
        send_symbol(SYM_PLUS, 1'b1);
    endtask

    // receiver holds off while short expressions keep coming
    task automatic test_result_backpressure();
        hold_request = 1'b1;
        repeat (30) begin
            send_symbol(digit($urandom_range(0, 9)), 1'b0);
            send_symbol(digit($urandom_range(0, 9)), 1'b0);
            send_symbol(random_operator(), 1'b1);
        end
    endtask

    // mostly well-formed expressions, some deep ones, some noise;
    // the last fifth runs with no idling on either side
    task automatic test_random_expressions();
        int goal;
        int pick;
        goal = symbols_sent + RANDOM_ITEMS;
        while (symbols_sent < goal) begin
            if (symbols_sent > goal - RANDOM_ITEMS / 5)
                idle_on = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 12)
                send_noise();
            else if (pick < 16)
                send_wellformed($urandom_range(20, 60), 1'b1, 1'b0);
            else
                send_wellformed($urandom_range(1, 10), $urandom_range(0, 3) == 0, 1'b1);
        end
    endtask

    initial begin
        rst_n     = 1'b0;
        sym_valid = 1'b0;
        sym_item  = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_arithmetic();
        test_underflow();
        test_divide_by_zero();
        test_most_negative_divide();
        test_overflow();
        test_result_backpressure();
        test_random_expressions();

        sym_valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("postfix_expression_evaluator verification clean");
        else
            $display("postfix_expression_evaluator verification failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/pfx_pkg.sv
rtl/pfx_ram.sv
rtl/postfix_expression_evaluator.sv
sim/tb.sv
